>>> sv/trw_pkg.sv
// shared types and constants of the trend ring window min/max recorder
`default_nettype none
package trw_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SETUP,
    S_SCAN,
    S_DONE
  } state_e;

  // configuration register indexes (byte address is four times the index)
  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_DECIMATE = 2'd1;
  localparam logic [1:0] REG_LOG_EN   = 2'd2;

  localparam logic [11:0] WINDOW_RESET   = 12'd120;
  localparam logic [7:0]  DECIMATE_RESET = 8'd2;
  localparam logic        LOG_EN_RESET   = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        time_ms;
    logic [7:0]         seq_tag;
    logic [15:0]        voltage_mv;
    logic signed [15:0] current_ma;
    logic [10:0]        read_index;
  } cmd_t;

  typedef struct packed {
    logic [11:0]        window_count;
    logic [15:0]        min_voltage;
    logic [15:0]        max_voltage;
    logic signed [15:0] min_current;
    logic signed [15:0] max_current;
    logic               chart_strobe;
    logic [11:0]        stored_count;
    logic               entry_valid;
    logic [31:0]        entry_time;
    logic [7:0]         entry_seq;
    logic [15:0]        entry_voltage;
    logic signed [15:0] entry_current;
  } result_t;

  typedef struct packed {
    logic [11:0] window_len;
    logic [7:0]  chart_decimation;
    logic        log_enable;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic setup;
    logic scan;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage
`default_nettype wire

>>> sv/trw_ram.sv
// generic single write port ram with registered read
`default_nettype none
module trw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/trw_ctrl.sv
// sequencing state machine of the trend ring window recorder
`default_nettype none
module trw_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire trw_pkg::dp_status_t  status_i,
  output trw_pkg::dp_cmd_t          cmd_o,
  output logic                      busy_o,
  output logic                      result_valid_o
);

  trw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trw_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trw_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = trw_pkg::S_EXEC;
        end
      end
      trw_pkg::S_EXEC:  state_d = trw_pkg::S_SETUP;
      trw_pkg::S_SETUP: state_d = trw_pkg::S_SCAN;
      trw_pkg::S_SCAN: begin
        if (status_i.scan_done) begin
          state_d = trw_pkg::S_DONE;
        end
      end
      trw_pkg::S_DONE:  state_d = trw_pkg::S_IDLE;
      default:          state_d = trw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      trw_pkg::S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      trw_pkg::S_EXEC:  cmd_o.exec  = 1'b1;
      trw_pkg::S_SETUP: cmd_o.setup = 1'b1;
      trw_pkg::S_SCAN:  cmd_o.scan  = 1'b1;
      trw_pkg::S_DONE:  result_valid_o = 1'b1;
      default:          busy_o = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/trw_dp.sv
// ring storage, pointers, entry read and window min/max walk
`default_nettype none
module trw_dp #(
  parameter int DEPTH = 2048
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire trw_pkg::dp_cmd_t     cmd_i,
  input  wire trw_pkg::cmd_t        item_i,
  input  wire trw_pkg::cfg_t        cfg_i,
  output trw_pkg::dp_status_t       status_o,
  output trw_pkg::result_t          result_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > 12) ? FW : 12;
  localparam int SW = FW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);

  // physical slot that lies back entries behind the write pointer
  function automatic logic [AW-1:0] wrap_back(logic [AW-1:0] wp, logic [FW-1:0] back);
    logic [SW-1:0] sum;
    sum = SW'(wp) + DEPTH_S - SW'(back);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  trw_pkg::cmd_t      item_q;
  logic [AW-1:0]      wp_q, wp_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [7:0]         dec_q, dec_d;
  logic               strobe_q, strobe_d;
  logic               ev_q, ev_d;
  logic [31:0]        etime_q;
  logic [7:0]         eseq_q;
  logic [15:0]        evolt_q;
  logic signed [15:0] ecur_q;
  logic [FW-1:0]      wc_q, rem_q;
  logic [AW-1:0]      saddr_q;
  logic               pend_q, first_q;
  logic [15:0]        vmin_q, vmax_q;
  logic signed [15:0] imin_q, imax_q;

  logic               we;
  logic [AW-1:0]      raddr;
  logic [31:0]        time_rd;
  logic [39:0]        samp_rd;
  logic [15:0]        rd_volt;
  logic signed [15:0] rd_cur;
  logic [CW-1:0]      fill_ext, win_ext, idx_ext;
  logic [FW-1:0]      wc_new;
  logic [7:0]         dec_n;
  logic [8:0]         dec_inc;
  logic               is_push, is_clear, is_read;

  assign is_push  = (item_q.opcode == trw_pkg::OP_PUSH);
  assign is_clear = (item_q.opcode == trw_pkg::OP_CLEAR);
  assign is_read  = (item_q.opcode == trw_pkg::OP_READ);

  assign fill_ext = CW'(fill_q);
  assign win_ext  = CW'(cfg_i.window_len);
  assign idx_ext  = CW'(item_q.read_index);
  assign wc_new   = (fill_ext > win_ext) ? FW'(win_ext) : fill_q;
  assign dec_n    = (cfg_i.chart_decimation == 8'd0) ? 8'd1 : cfg_i.chart_decimation;
  assign dec_inc  = {1'b0, dec_q} + 9'd1;

  assign we    = cmd_i.exec && is_push && cfg_i.log_enable;
  assign raddr = cmd_i.exec ? wrap_back(wp_q, FW'(fill_ext - idx_ext)) : saddr_q;

  trw_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (item_q.time_ms),
    .raddr_i (raddr),
    .rdata_o (time_rd)
  );

  trw_ram #(.WIDTH(40), .DEPTH(DEPTH)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i ({item_q.seq_tag, item_q.voltage_mv, item_q.current_ma}),
    .raddr_i (raddr),
    .rdata_o (samp_rd)
  );

  assign rd_volt = samp_rd[31:16];
  assign rd_cur  = samp_rd[15:0];

  // pointer, fill and decimation updates of the executed item
  always_comb begin
    wp_d     = wp_q;
    fill_d   = fill_q;
    dec_d    = dec_q;
    strobe_d = strobe_q;
    ev_d     = ev_q;
    if (cmd_i.exec) begin
      strobe_d = 1'b0;
      ev_d     = 1'b0;
      if (we) begin
        wp_d = (wp_q == LAST_A) ? '0 : wp_q + 1'b1;
        if (fill_q < DEPTH_F) begin
          fill_d = fill_q + 1'b1;
        end
        if (dec_inc >= {1'b0, dec_n}) begin
          strobe_d = 1'b1;
          dec_d    = '0;
        end else begin
          dec_d = dec_inc[7:0];
        end
      end else if (is_clear) begin
        wp_d   = '0;
        fill_d = '0;
        dec_d  = '0;
      end else if (is_read) begin
        ev_d = (idx_ext < fill_ext);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      fill_q  <= '0;
      dec_q   <= '0;
      rem_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      dec_q  <= dec_d;
      if (cmd_i.setup) begin
        rem_q  <= wc_new;
        pend_q <= 1'b0;
      end else if (cmd_i.scan) begin
        pend_q <= (rem_q != '0);
        if (rem_q != '0) begin
          rem_q <= rem_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    strobe_q <= strobe_d;
    ev_q     <= ev_d;
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.setup) begin
      etime_q <= ev_q ? time_rd : 32'd0;
      eseq_q  <= ev_q ? samp_rd[39:32] : 8'd0;
      evolt_q <= ev_q ? rd_volt : 16'd0;
      ecur_q  <= ev_q ? rd_cur : 16'sd0;
      wc_q    <= wc_new;
      saddr_q <= wrap_back(wp_q, wc_new);
      first_q <= 1'b1;
      vmin_q  <= '0;
      vmax_q  <= '0;
      imin_q  <= '0;
      imax_q  <= '0;
    end else if (cmd_i.scan) begin
      if (rem_q != '0) begin
        saddr_q <= (saddr_q == LAST_A) ? '0 : saddr_q + 1'b1;
      end
      // ram read data is registered, so it arrives in the cycle after its address
      if (pend_q) begin
        first_q <= 1'b0;
        if (first_q || rd_volt < vmin_q) vmin_q <= rd_volt;
        if (first_q || rd_volt > vmax_q) vmax_q <= rd_volt;
        if (first_q || rd_cur < imin_q)  imin_q <= rd_cur;
        if (first_q || rd_cur > imax_q)  imax_q <= rd_cur;
      end
    end
  end

  assign status_o.scan_done = (rem_q == '0) && !pend_q;

  always_comb begin
    result_o.window_count  = 12'(wc_q);
    result_o.min_voltage   = vmin_q;
    result_o.max_voltage   = vmax_q;
    result_o.min_current   = imin_q;
    result_o.max_current   = imax_q;
    result_o.chart_strobe  = strobe_q;
    result_o.stored_count  = 12'(fill_q);
    result_o.entry_valid   = ev_q;
    result_o.entry_time    = etime_q;
    result_o.entry_seq     = eseq_q;
    result_o.entry_voltage = evolt_q;
    result_o.entry_current = ecur_q;
  end

endmodule
`default_nettype wire

>>> sv/trend_ring_window_min_max_core.sv
// top level: configuration registers, controller and datapath of the trace recorder
`default_nettype none
// Trace recorder that keeps the newest DEPTH voltage/current samples in a ring
// and answers every command (push, clear, read, no-op) with one result beat:
// the min/max over the newest window_len stored samples, the fill count,
// the chart strobe and, for a read, the addressed entry. A command is taken
// when start is high and busy is low; its result appears on result_o for one
// cycle with result_valid_o high and cannot be held off. From one accepted
// command to the next, the block steps through its exec, setup, scan and
// done states and keeps busy high through the result beat; the scan covers
// the smaller of window_len and the stored count, since the single read
// port of the sample memory walks the window one entry per cycle. Memory
// contents need no clearing after reset.
module trend_ring_window_min_max_core #(
  parameter int DEPTH = 2048
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire trw_pkg::cmd_t    cmd_i,
  output logic                  result_valid_o,
  output trw_pkg::result_t      result_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  trw_pkg::cfg_t       cfg_q;
  trw_pkg::dp_cmd_t    dp_cmd;
  trw_pkg::dp_status_t dp_status;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len       <= trw_pkg::WINDOW_RESET;
      cfg_q.chart_decimation <= trw_pkg::DECIMATE_RESET;
      cfg_q.log_enable       <= trw_pkg::LOG_EN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        trw_pkg::REG_WINDOW:   cfg_q.window_len       <= pwdata[11:0];
        trw_pkg::REG_DECIMATE: cfg_q.chart_decimation <= pwdata[7:0];
        trw_pkg::REG_LOG_EN:   cfg_q.log_enable       <= pwdata[0];
        default:               cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      trw_pkg::REG_WINDOW:   prdata = {20'd0, cfg_q.window_len};
      trw_pkg::REG_DECIMATE: prdata = {24'd0, cfg_q.chart_decimation};
      trw_pkg::REG_LOG_EN:   prdata = {31'd0, cfg_q.log_enable};
      default:               prdata = 32'd0;
    endcase
  end

  trw_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .status_i       (dp_status),
    .cmd_o          (dp_cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  trw_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (dp_cmd),
    .item_i   (cmd_i),
    .cfg_i    (cfg_q),
    .status_o (dp_status),
    .result_o (result_o)
  );

  // a result beat ends the command
  a_done_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy && !result_valid_o)
    else $error("busy still high after result beat");

  // no result beat right after a command is taken
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !result_valid_o)
    else $error("accepted command did not raise busy");

  // empty window reports zero min/max
  a_empty_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.window_count == 12'd0 |->
      result_o.min_voltage == 16'd0 && result_o.max_voltage == 16'd0 &&
      result_o.min_current == 16'sd0 && result_o.max_current == 16'sd0)
    else $error("nonzero min/max with empty window");

  // entry fields are zero when the read missed
  a_entry_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.entry_valid |->
      result_o.entry_time == 32'd0 && result_o.entry_seq == 8'd0)
    else $error("entry fields set on invalid read");

endmodule
`default_nettype wire
